### rtl/tcsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcsq_pkg;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned KEY_W = 32;

  // operation codes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_POP    = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_POPPED   = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  // one storage cell as seen by its neighbours
  typedef struct packed {
    logic   vld;
    entry_t ent;
  } cell_t;

  // per-store operation strobes
  typedef struct packed {
    logic ins;
    logic pop;
  } store_ctl_t;

  typedef struct packed {
    logic             mode;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] sort_key;
    logic             class_flag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ID_W-1:0]  out_id;
    logic [KEY_W-1:0] out_key;
    logic             out_class;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/tcsq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One slot of a sorted store. ge_o flags that the new key belongs here or
// earlier; the head slot only claims the key when it is strictly smaller.
module tcsq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcsq_pkg::store_ctl_t  ctl,
  input  tcsq_pkg::entry_t      new_ent,
  input  tcsq_pkg::cell_t       prev_cell,
  input  wire                   prev_ge,
  input  tcsq_pkg::cell_t       next_cell,
  output tcsq_pkg::cell_t       cell_o,
  output logic                  ge_o
);

  logic             vld_r, vld_nxt;
  tcsq_pkg::entry_t ent_r, ent_nxt;

  always_comb begin
    if (IS_HEAD) begin
      ge_o = !vld_r || ($signed(new_ent.key) < $signed(ent_r.key));
    end else begin
      ge_o = !vld_r || !($signed(ent_r.key) < $signed(new_ent.key));
    end
  end

  // insert: slots behind the claiming one take their neighbour's entry
  always_comb begin
    priority if (ctl.ins && prev_ge) begin
      vld_nxt = prev_cell.vld;
      ent_nxt = prev_cell.ent;
    end else if (ctl.ins && ge_o) begin
      vld_nxt = 1'b1;
      ent_nxt = new_ent;
    end else if (ctl.pop) begin
      vld_nxt = next_cell.vld;
      ent_nxt = next_cell.ent;
    end else begin
      vld_nxt = vld_r;
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign cell_o = '{vld: vld_r, ent: ent_r};

endmodule

`default_nettype wire

### rtl/tcsq_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Sorted store for one class: a row of cells, head at index 0.
module tcsq_store #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  tcsq_pkg::store_ctl_t  ctl,
  input  tcsq_pkg::entry_t      new_ent,
  output tcsq_pkg::cell_t       head,
  output logic                  full,
  output logic                  empty
);

  tcsq_pkg::cell_t cells [DEPTH];
  logic            ge    [DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      tcsq_pkg::cell_t prev_c, next_c;
      logic            prev_g;

      if (gi == 0) begin : g_first
        assign prev_c = '0;
        assign prev_g = 1'b0;
      end else begin : g_mid
        assign prev_c = cells[gi-1];
        assign prev_g = ge[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_last
        assign next_c = '0;
      end else begin : g_inner
        assign next_c = cells[gi+1];
      end

      tcsq_cell #(
        .IS_HEAD (gi == 0)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_ent   (new_ent),
        .prev_cell (prev_c),
        .prev_ge   (prev_g),
        .next_cell (next_c),
        .cell_o    (cells[gi]),
        .ge_o      (ge[gi])
      );
    end
  endgenerate

  assign head  = cells[0];
  assign empty = !cells[0].vld;
  assign full  = cells[DEPTH-1].vld;

endmodule

`default_nettype wire

### rtl/two_class_sorted_queue_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// The result of a transaction appears in the cycle after it is taken.
// Throughput: one transaction per cycle; every cell of both stores compares
// its key in parallel, so busy never rises.
// Reset: synchronous, active low; empties both stores and drops the strobe.
// The receiver cannot stall: out_valid is high for exactly one cycle.
module two_class_sorted_queue_merge #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  tcsq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output tcsq_pkg::out_item_t  out_data
);

  // Each store is a chain of cells kept in ascending key order. An insert
  // shifts the tail of the chain up by one behind the slot that claims the
  // key; a pop shifts the whole chain down by one.

  logic                 accept;
  logic                 is_pop;
  tcsq_pkg::entry_t     new_ent;
  tcsq_pkg::store_ctl_t ctl0, ctl1;
  tcsq_pkg::cell_t      head0, head1;
  logic                 full0, full1, empty0, empty1;
  logic                 pick;       // store that a pop takes from
  logic                 both_empty;
  logic                 tgt_full;

  logic                 out_valid_r, out_valid_nxt;
  tcsq_pkg::out_item_t  out_data_r, out_data_nxt;

  assign busy    = 1'b0;            // no transaction ever stalls the inputs
  assign accept  = start && !busy;
  assign is_pop  = (in_data.mode == tcsq_pkg::MODE_POP);
  assign new_ent = '{id: in_data.item_id, key: in_data.sort_key};

  assign both_empty = empty0 && empty1;
  assign tgt_full   = in_data.class_flag ? full1 : full0;

  // merge: smaller head wins, class 1 on a tie
  always_comb begin
    priority if (empty0) begin
      pick = 1'b1;
    end else if (empty1) begin
      pick = 1'b0;
    end else begin
      pick = ($signed(head0.ent.key) < $signed(head1.ent.key)) ? 1'b0 : 1'b1;
    end
  end

  always_comb begin
    ctl0.ins = accept && !is_pop && !in_data.class_flag && !full0;
    ctl1.ins = accept && !is_pop &&  in_data.class_flag && !full1;
    ctl0.pop = accept &&  is_pop && !both_empty && !pick;
    ctl1.pop = accept &&  is_pop && !both_empty &&  pick;
  end

  tcsq_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl0),
    .new_ent (new_ent),
    .head    (head0),
    .full    (full0),
    .empty   (empty0)
  );

  tcsq_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl1),
    .new_ent (new_ent),
    .head    (head1),
    .full    (full1),
    .empty   (empty1)
  );

  // result register
  always_comb begin
    out_valid_nxt = accept;
    out_data_nxt  = '0;
    priority if (!is_pop) begin
      out_data_nxt.status = tgt_full ? tcsq_pkg::STAT_FULL : tcsq_pkg::STAT_INSERTED;
    end else if (both_empty) begin
      out_data_nxt.status = tcsq_pkg::STAT_EMPTY;
    end else begin
      out_data_nxt.status    = tcsq_pkg::STAT_POPPED;
      out_data_nxt.out_id    = pick ? head1.ent.id  : head0.ent.id;
      out_data_nxt.out_key   = pick ? head1.ent.key : head0.ent.key;
      out_data_nxt.out_class = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/tcsq_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module tcsq_chk (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  start,
  input wire                  busy,
  input tcsq_pkg::in_item_t   in_data,
  input wire                  out_valid,
  input tcsq_pkg::out_item_t  out_data
);

  // one result per transaction, in the following cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow transaction");

  // insert outcomes come only from inserts
  a_ins_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == tcsq_pkg::STAT_INSERTED ||
                  out_data.status == tcsq_pkg::STAT_FULL)
    |-> $past(in_data.mode) == tcsq_pkg::MODE_INSERT)
    else $error("insert status on a pop");

  // pop outcomes come only from pops
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == tcsq_pkg::STAT_POPPED ||
                  out_data.status == tcsq_pkg::STAT_EMPTY)
    |-> $past(in_data.mode) == tcsq_pkg::MODE_POP)
    else $error("pop status on an insert");

  // only a real pop carries payload
  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != tcsq_pkg::STAT_POPPED
    |-> out_data.out_id == '0 && out_data.out_key == '0 && out_data.out_class == 1'b0)
    else $error("payload on a non-pop result");

endmodule

bind two_class_sorted_queue_merge tcsq_chk u_tcsq_chk (.*);

`default_nettype wire
